// ===== rtl/ttiu_pkg.sv =====
// Shared types, constants and codes for the trilinear table interpolation unit.
// Used by ttiu_ctrl, ttiu_dp and the top level; depends on nothing else.
package ttiu_pkg;

  localparam int MAX_TEMP_BINS  = 64;
  localparam int MAX_GRAV_BINS  = 16;
  localparam int MAX_METAL_BINS = 16;
  localparam int FRAC_BITS      = 8;

  localparam int TW  = $clog2(MAX_TEMP_BINS);
  localparam int GW  = $clog2(MAX_GRAV_BINS);
  localparam int ZW  = $clog2(MAX_METAL_BINS);
  localparam int TBW = 7;
  localparam int GBW = 5;
  localparam int ZBW = 5;

  localparam int TBL_AW    = TW + GW + ZW;
  localparam int TBL_DEPTH = 1 << TBL_AW;

  localparam int CNT_W  = (TW > 4) ? TW : 4;
  localparam int FRAC_W = FRAC_BITS + 1;
  localparam int QUO_W  = FRAC_BITS + 2;

  localparam logic signed [31:0] ONE = 32'(1 << FRAC_BITS);

  localparam int CORNERS      = 8;
  localparam int LERP_T_STEPS = 4;
  localparam int LERP_G_STEPS = 2;
  localparam int LERP_STEPS   = 7;

  localparam logic [2:0] OP_TEMP_AXIS  = 3'd0;
  localparam logic [2:0] OP_GRAV_AXIS  = 3'd1;
  localparam logic [2:0] OP_METAL_AXIS = 3'd2;
  localparam logic [2:0] OP_Q0_ENTRY   = 3'd3;
  localparam logic [2:0] OP_Q1_ENTRY   = 3'd4;
  localparam logic [2:0] OP_QUERY      = 3'd5;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_TEMP_OUT  = 3'd1;
  localparam logic [2:0] STAT_GRAV_OUT  = 3'd2;
  localparam logic [2:0] STAT_METAL_OUT = 3'd3;
  localparam logic [2:0] STAT_UNSAMPLED = 3'd4;

  localparam logic [1:0] CFG_TEMP_BINS   = 2'd0;
  localparam logic [1:0] CFG_GRAV_BINS   = 2'd1;
  localparam logic [1:0] CFG_METAL_BINS  = 2'd2;
  localparam logic [1:0] CFG_METAL_SCALE = 2'd3;

  typedef struct packed {
    logic [2:0]         op;
    logic [TW-1:0]      index_t;
    logic [GW-1:0]      index_g;
    logic [ZW-1:0]      index_z;
    logic signed [31:0] write_value;
    logic signed [31:0] query_temp;
    logic signed [31:0] query_gravity;
    logic signed [31:0] query_metal;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] q0_rate;
    logic signed [31:0] q1_rate;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_SAT, S_SCAN, S_SDRAIN, S_DIV_INIT, S_DIV,
    S_CORNER, S_CDRAIN, S_LERP, S_OUT
  } fsm_state_t;

  typedef enum logic [1:0] {LERP_NONE, LERP_T, LERP_G, LERP_Z} lerp_op_t;

  typedef struct packed {
    logic             write;
    logic             capture;
    logic             mul;
    logic             sat;
    logic             scan_rd;
    logic             div_init;
    logic             div_step;
    logic             corner_rd;
    lerp_op_t         lerp;
    logic             load_out;
    logic [CNT_W-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] scan_last;
    logic             out_free;
  } dp_stat_t;

endpackage

// ===== rtl/ttiu_ctrl.sv =====
// Sequencer for the interpolation unit: steps a query through scaling, axis scan,
// division, corner reads and interpolation. Depends on ttiu_pkg.
module ttiu_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic [2:0]         in_op,
  output logic               in_ready,
  input  ttiu_pkg::dp_stat_t st,
  output ttiu_pkg::dp_cmd_t  cmd
);
  import ttiu_pkg::*;

  fsm_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_fire && in_op == OP_QUERY) state_nxt = S_MUL;
      end
      S_MUL: state_nxt = S_SAT;
      S_SAT: state_nxt = S_SCAN;
      S_SCAN: begin
        if (cnt_r == st.scan_last) begin
          state_nxt = S_SDRAIN;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_SDRAIN:   state_nxt = S_DIV_INIT;
      S_DIV_INIT: state_nxt = S_DIV;
      S_DIV: begin
        if (cnt_r == CNT_W'(QUO_W - 1)) begin
          state_nxt = S_CORNER;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_CORNER: begin
        if (cnt_r == CNT_W'(CORNERS - 1)) begin
          state_nxt = S_CDRAIN;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_CDRAIN: state_nxt = S_LERP;
      S_LERP: begin
        if (cnt_r == CNT_W'(LERP_STEPS - 1)) begin
          state_nxt = S_OUT;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_OUT: if (st.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    cmd.lerp = LERP_NONE;
    cmd.idx  = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.write   = in_fire;
        cmd.capture = in_fire && in_op == OP_QUERY;
      end
      S_MUL:      cmd.mul = 1'b1;
      S_SAT:      cmd.sat = 1'b1;
      S_SCAN:     cmd.scan_rd = 1'b1;
      S_SDRAIN:   ;
      S_DIV_INIT: cmd.div_init = 1'b1;
      S_DIV:      cmd.div_step = 1'b1;
      S_CORNER:   cmd.corner_rd = 1'b1;
      S_CDRAIN:   ;
      S_LERP: begin
        if (cnt_r < CNT_W'(LERP_T_STEPS))                     cmd.lerp = LERP_T;
        else if (cnt_r < CNT_W'(LERP_T_STEPS + LERP_G_STEPS)) cmd.lerp = LERP_G;
        else                                                  cmd.lerp = LERP_Z;
      end
      S_OUT: cmd.load_out = st.out_free;
      default: ;
    endcase
  end

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (cnt_r <= st.scan_last))
    else $error("scan index ran past the last axis point");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> st.out_free)
    else $error("result loaded while the output register was still full");

  a_query_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_op == OP_QUERY) |=> (state_r == S_MUL))
    else $error("accepted query did not start the sequence");

  a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && st.out_free) |=> (state_r == S_IDLE))
    else $error("sequencer did not return to idle after loading a result");

endmodule

// ===== rtl/ttiu_dp.sv =====
// Datapath of the interpolation unit: configuration registers, axis and table
// memories, bracket scan, fraction dividers, lerp units and output register.
// Depends on ttiu_pkg.
module ttiu_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  ttiu_pkg::dp_cmd_t   cmd,
  output ttiu_pkg::dp_stat_t  st,
  input  ttiu_pkg::in_item_t  in_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_addr,
  input  logic [31:0]         cfg_wdata,
  output logic                out_valid,
  input  logic                out_ready,
  output ttiu_pkg::out_item_t out_data
);
  import ttiu_pkg::*;

  localparam int REM_W = 33 + FRAC_BITS + 1;
  localparam int CMP_W = 33 + QUO_W;
  localparam int PRD_W = 33 + FRAC_W + 1;

  function automatic logic signed [31:0] lerp(input logic signed [31:0] a,
                                              input logic signed [31:0] b,
                                              input logic [FRAC_W-1:0] f);
    logic signed [32:0]      diff;
    logic signed [PRD_W-1:0] prod;
    diff = {b[31], b} - {a[31], a};
    prod = diff * $signed({1'b0, f});
    // The result always lies between a and b, so wrapping to 32 bits is exact.
    return a + 32'(prod >>> FRAC_BITS);
  endfunction

  // Configuration.
  logic [TBW-1:0] temp_bins_r;
  logic [GBW-1:0] grav_bins_r;
  logic [ZBW-1:0] metal_bins_r;
  logic [31:0]    metal_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_bins_r   <= TBW'(MAX_TEMP_BINS);
      grav_bins_r   <= GBW'(MAX_GRAV_BINS);
      metal_bins_r  <= ZBW'(MAX_METAL_BINS);
      metal_scale_r <= 32'd65536;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_TEMP_BINS:   temp_bins_r   <= cfg_wdata[TBW-1:0];
        CFG_GRAV_BINS:   grav_bins_r   <= cfg_wdata[GBW-1:0];
        CFG_METAL_BINS:  metal_bins_r  <= cfg_wdata[ZBW-1:0];
        CFG_METAL_SCALE: metal_scale_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [TBW-1:0] ax_bins [3];
  logic [TBW-1:0] bins_max;

  always_comb begin
    if (temp_bins_r < TBW'(2))                  ax_bins[0] = TBW'(2);
    else if (temp_bins_r > TBW'(MAX_TEMP_BINS)) ax_bins[0] = TBW'(MAX_TEMP_BINS);
    else                                        ax_bins[0] = temp_bins_r;
    if (grav_bins_r < GBW'(2))                  ax_bins[1] = TBW'(2);
    else if (grav_bins_r > GBW'(MAX_GRAV_BINS)) ax_bins[1] = TBW'(MAX_GRAV_BINS);
    else                                        ax_bins[1] = TBW'(grav_bins_r);
    if (metal_bins_r < ZBW'(2))                   ax_bins[2] = TBW'(2);
    else if (metal_bins_r > ZBW'(MAX_METAL_BINS)) ax_bins[2] = TBW'(MAX_METAL_BINS);
    else                                          ax_bins[2] = TBW'(metal_bins_r);
    bins_max = ax_bins[0];
    if (ax_bins[1] > bins_max) bins_max = ax_bins[1];
    if (ax_bins[2] > bins_max) bins_max = ax_bins[2];
  end

  assign st.scan_last = CNT_W'(bins_max - TBW'(1));

  // Query capture and metallicity scaling.
  logic signed [31:0] qtemp_r, qgrav_r, qmetal_r, zq_r;
  logic signed [65:0] prod_r;
  logic signed [49:0] zsh;

  assign zsh = prod_r[65:16];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      qtemp_r  <= in_data.query_temp;
      qgrav_r  <= in_data.query_gravity;
      qmetal_r <= in_data.query_metal;
    end
    if (cmd.mul) prod_r <= $signed({qmetal_r[31], qmetal_r}) * $signed({1'b0, metal_scale_r});
    if (cmd.sat) begin
      if (zsh > 50'sd2147483647)       zq_r <= 32'sh7fffffff;
      else if (zsh < -50'sd2147483648) zq_r <= 32'sh80000000;
      else                             zq_r <= zsh[31:0];
    end
  end

  // Axis memories.
  logic signed [31:0] temp_mem  [MAX_TEMP_BINS];
  logic signed [31:0] grav_mem  [MAX_GRAV_BINS];
  logic signed [31:0] metal_mem [MAX_METAL_BINS];
  logic signed [31:0] ax_rd_r   [3];

  always_ff @(posedge clk) begin
    if (cmd.write && in_data.op == OP_TEMP_AXIS) temp_mem[in_data.index_t] <= in_data.write_value;
    if (cmd.write && in_data.op == OP_GRAV_AXIS) grav_mem[in_data.index_g] <= in_data.write_value;
    if (cmd.write && in_data.op == OP_METAL_AXIS) metal_mem[in_data.index_z] <= in_data.write_value;
    if (cmd.scan_rd) begin
      ax_rd_r[0] <= temp_mem[cmd.idx[TW-1:0]];
      ax_rd_r[1] <= grav_mem[cmd.idx[GW-1:0]];
      ax_rd_r[2] <= metal_mem[cmd.idx[ZW-1:0]];
    end
  end

  // Bracket scan: one point of each axis per cycle.
  logic               scan_vld_r;
  logic [CNT_W-1:0]   scan_k_r;
  logic signed [31:0] ax_x [3];
  logic signed [31:0] first_r [3], last_r [3], lo_r [3], hi_r [3];
  logic [CNT_W-1:0]   brk_r [3];
  logic               cap_r [3];
  logic [TBW-1:0]     k_ext;

  assign ax_x[0] = qtemp_r;
  assign ax_x[1] = qgrav_r;
  assign ax_x[2] = zq_r;
  assign k_ext   = TBW'(scan_k_r);

  always_ff @(posedge clk) begin
    if (!rst_n) scan_vld_r <= 1'b0;
    else        scan_vld_r <= cmd.scan_rd;
    scan_k_r <= cmd.idx;
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      if (scan_vld_r && k_ext < ax_bins[a]) begin
        // The candidate follows the last point at or below x; the point after
        // it is caught on the next read.
        if (k_ext == '0) begin
          first_r[a] <= ax_rd_r[a];
          lo_r[a]    <= ax_rd_r[a];
          brk_r[a]   <= '0;
          cap_r[a]   <= 1'b1;
        end else if (k_ext <= ax_bins[a] - TBW'(2) && ax_rd_r[a] <= ax_x[a]) begin
          lo_r[a]  <= ax_rd_r[a];
          brk_r[a] <= scan_k_r;
          cap_r[a] <= 1'b1;
        end else if (cap_r[a]) begin
          hi_r[a]  <= ax_rd_r[a];
          cap_r[a] <= 1'b0;
        end
        if (k_ext == ax_bins[a] - TBW'(1)) last_r[a] <= ax_rd_r[a];
      end
    end
  end

  // Fraction dividers, one quotient bit per cycle on each axis.
  logic signed [32:0] num [3], den [3];
  logic [REM_W-1:0]   rem_r [3], dsh_r [3];
  logic [QUO_W-1:0]   quo_r [3];
  logic               zero_r [3], sat_r [3];
  logic [FRAC_W-1:0]  frac [3];
  logic               out_rng [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      num[a] = {ax_x[a][31], ax_x[a]} - {lo_r[a][31], lo_r[a]};
      den[a] = {hi_r[a][31], hi_r[a]} - {lo_r[a][31], lo_r[a]};
      if (zero_r[a])
        frac[a] = '0;
      else if (sat_r[a] || quo_r[a] > QUO_W'(ONE))
        frac[a] = FRAC_W'(ONE);
      else
        frac[a] = quo_r[a][FRAC_W-1:0];
      out_rng[a] = ax_x[a] < first_r[a] || ax_x[a] > last_r[a];
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      if (cmd.div_init) begin
        zero_r[a] <= den[a] <= 33'sd0 || num[a] <= 33'sd0;
        rem_r[a]  <= {1'b0, num[a], FRAC_BITS'(0)};
        dsh_r[a]  <= {den[a], (QUO_W - 1)'(0)};
        sat_r[a]  <= {2'b0, num[a], FRAC_BITS'(0)} >= {den[a], QUO_W'(0)};
        quo_r[a]  <= '0;
      end else if (cmd.div_step) begin
        if (rem_r[a] >= dsh_r[a]) begin
          rem_r[a] <= rem_r[a] - dsh_r[a];
          quo_r[a] <= {quo_r[a][QUO_W-2:0], 1'b1};
        end else begin
          quo_r[a] <= {quo_r[a][QUO_W-2:0], 1'b0};
        end
        dsh_r[a] <= dsh_r[a] >> 1;
      end
    end
  end

  // Value tables, both read at the same corner each cycle.
  logic signed [31:0] q0_mem [TBL_DEPTH];
  logic signed [31:0] q1_mem [TBL_DEPTH];
  logic signed [31:0] tb_rd_r [2];
  logic [TBL_AW-1:0]  wr_addr, corner_addr;
  logic [TW-1:0]      ct;
  logic [GW-1:0]      cg;
  logic [ZW-1:0]      cz;

  assign wr_addr     = {in_data.index_t, in_data.index_g, in_data.index_z};
  assign ct          = brk_r[0][TW-1:0] + TW'(cmd.idx[0]);
  assign cg          = brk_r[1][GW-1:0] + GW'(cmd.idx[1]);
  assign cz          = brk_r[2][ZW-1:0] + ZW'(cmd.idx[2]);
  assign corner_addr = {ct, cg, cz};

  always_ff @(posedge clk) begin
    if (cmd.write && in_data.op == OP_Q0_ENTRY) q0_mem[wr_addr] <= in_data.write_value;
    if (cmd.write && in_data.op == OP_Q1_ENTRY) q1_mem[wr_addr] <= in_data.write_value;
    if (cmd.corner_rd) begin
      tb_rd_r[0] <= q0_mem[corner_addr];
      tb_rd_r[1] <= q1_mem[corner_addr];
    end
  end

  // Corner shift line and staged lerps, temperature first.
  logic               corner_vld_r, sent_r;
  logic signed [31:0] c_sh_r [2][8];
  logic signed [31:0] e_sh_r [2][4];
  logic signed [31:0] g_sh_r [2][2];
  logic signed [31:0] res_r [2];
  logic signed [31:0] lr_a [2], lr_b [2], lr_y [2];
  logic [FRAC_W-1:0]  lr_f;

  always_ff @(posedge clk) begin
    if (!rst_n) corner_vld_r <= 1'b0;
    else        corner_vld_r <= cmd.corner_rd;
    if (cmd.capture) sent_r <= 1'b0;
    else if (corner_vld_r && (tb_rd_r[0] == ONE || tb_rd_r[1] == ONE)) sent_r <= 1'b1;
  end

  always_comb begin
    case (cmd.lerp)
      LERP_G:  lr_f = frac[1];
      LERP_Z:  lr_f = frac[2];
      default: lr_f = frac[0];
    endcase
    for (int t = 0; t < 2; t++) begin
      case (cmd.lerp)
        LERP_G: begin
          lr_a[t] = e_sh_r[t][0];
          lr_b[t] = e_sh_r[t][1];
        end
        LERP_Z: begin
          lr_a[t] = g_sh_r[t][0];
          lr_b[t] = g_sh_r[t][1];
        end
        default: begin
          lr_a[t] = c_sh_r[t][0];
          lr_b[t] = c_sh_r[t][1];
        end
      endcase
      lr_y[t] = lerp(lr_a[t], lr_b[t], lr_f);
    end
  end

  always_ff @(posedge clk) begin
    for (int t = 0; t < 2; t++) begin
      if (corner_vld_r) begin
        for (int i = 0; i < 7; i++) c_sh_r[t][i] <= c_sh_r[t][i+1];
        c_sh_r[t][7] <= tb_rd_r[t];
      end else if (cmd.lerp == LERP_T) begin
        for (int i = 0; i < 6; i++) c_sh_r[t][i] <= c_sh_r[t][i+2];
        for (int i = 0; i < 3; i++) e_sh_r[t][i] <= e_sh_r[t][i+1];
        e_sh_r[t][3] <= lr_y[t];
      end else if (cmd.lerp == LERP_G) begin
        e_sh_r[t][0] <= e_sh_r[t][2];
        e_sh_r[t][1] <= e_sh_r[t][3];
        g_sh_r[t][0] <= g_sh_r[t][1];
        g_sh_r[t][1] <= lr_y[t];
      end else if (cmd.lerp == LERP_Z) begin
        res_r[t] <= lr_y[t];
      end
    end
  end

  // Output register.
  logic       out_valid_r;
  out_item_t  out_data_r;
  logic [2:0] status;

  always_comb begin
    if (out_rng[0])      status = STAT_TEMP_OUT;
    else if (out_rng[1]) status = STAT_GRAV_OUT;
    else if (out_rng[2]) status = STAT_METAL_OUT;
    else if (sent_r)     status = STAT_UNSAMPLED;
    else                 status = STAT_OK;
  end

  assign st.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.load_out) begin
      out_data_r.status  <= status;
      out_data_r.q0_rate <= (status == STAT_OK) ? res_r[0] : 32'sd0;
      out_data_r.q1_rate <= (status == STAT_OK) ? res_r[1] : 32'sd0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/trilinear_table_interpolation_unit.sv =====
// Top level of the trilinear table interpolation unit.
// Instantiates ttiu_ctrl and ttiu_dp; depends on ttiu_pkg.
//
// Axis and table writes are taken one beat per cycle while the unit is idle.
// A query beat produces one result beat. The bracket scan reads one point of
// every axis memory per cycle for N points, where N is the largest of the three
// clamped bins counts; it is followed by ten divider steps, eight corner reads
// at one corner address shared by the two table memories and seven lerp steps.
// Once the output register is free the result is loaded and the unit returns to
// idle. A finished result waits in the output register while the next beat is
// taken. The axis and table memories are not cleared by reset; query results
// that touch unwritten entries are undefined.
module trilinear_table_interpolation_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ttiu_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ttiu_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_addr,
  input  logic [31:0]         cfg_wdata
);
  import ttiu_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t st;
  logic     in_fire;

  assign in_fire = in_valid && in_ready;

  ttiu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_op    (in_data.op),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  ttiu_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
